// File: rtl/indexed_min_heap_queue_defines.svh
// assertion macros for the heap queue
`ifndef INDEXED_MIN_HEAP_QUEUE_DEFINES_SVH
`define INDEXED_MIN_HEAP_QUEUE_DEFINES_SVH

// same-cycle implication
`define IMHQ_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("imhq check failed");

// next-cycle implication
`define IMHQ_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("imhq check failed");

`endif

// File: rtl/imhq_pkg.sv
package imhq_pkg;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_DELETE = 2'd1;
   localparam logic [1:0] OP_ALTER  = 2'd2;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_FULL   = 2'd1,
      ST_EMPTY  = 2'd2,
      ST_ABSENT = 2'd3
   } status_type;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [7:0]  entry_id;
      logic [31:0] new_key;
   } req_item_type;

   typedef struct packed {
      logic        min_valid;
      logic [31:0] min_key;
      logic [7:0]  min_id;
      logic [7:0]  entry_count;
      status_type  status;
   } rsp_item_type;

endpackage

// File: rtl/imhq_ifs.sv
interface imhq_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [7:0]  entry_id;
   logic [31:0] new_key;
   modport source (output valid, output req_type, output entry_id, output new_key,
                   input ready);
   modport sink (input valid, input req_type, input entry_id, input new_key,
                 output ready);
endinterface

interface imhq_rsp_if;
   logic        valid;
   logic        ready;
   logic        min_valid;
   logic [31:0] min_key;
   logic [7:0]  min_id;
   logic [7:0]  entry_count;
   logic [1:0]  status;
   modport source (output valid, output min_valid, output min_key, output min_id,
                   output entry_count, output status, input ready);
   modport sink (input valid, input min_valid, input min_key, input min_id,
                 input entry_count, input status, output ready);
endinterface

// File: rtl/indexed_min_heap_queue.sv
// one request at a time; a delete walks the heap down level by level through S_DN_L,
// S_DN_R and S_DN_C, and a sift up goes through S_UP_P and S_UP_C per level, both paced
// by the single read port of the heap memory
// the next request is taken the cycle after its result is loaded into the output register
// reset is synchronous: count and location valid bits clear at once, no clearing pass
`include "indexed_min_heap_queue_defines.svh"
module indexed_min_heap_queue
   import imhq_pkg::*;
#(
   parameter int HEAP_SLOTS = 256,
   parameter int ENTRY_IDS  = 256,
   parameter int KEY_BITS   = 32
) (
   input logic       clock,
   input logic       reset,
   imhq_req_if.sink   req_ch,
   imhq_rsp_if.source rsp_ch
);

   req_item_type start_item;
   rsp_item_type result;
   rsp_item_type rsp_ff;
   logic         rsp_vld_ff;
   logic         seq_idle, seq_done, start, out_free;
   logic         rsp_min_zero;

   assign start_item.req_type = req_ch.req_type;
   assign start_item.entry_id = req_ch.entry_id;
   assign start_item.new_key  = req_ch.new_key;

   assign req_ch.ready = seq_idle;
   assign start        = req_ch.valid && seq_idle;
   assign out_free     = !rsp_vld_ff || rsp_ch.ready;

   imhq_seq #(
      .HEAP_SLOTS (HEAP_SLOTS),
      .ENTRY_IDS  (ENTRY_IDS),
      .KEY_BITS   (KEY_BITS)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .start_item (start_item),
      .out_free   (out_free),
      .idle       (seq_idle),
      .done       (seq_done),
      .result     (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (seq_done) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_vld_ff <= 1'b0;
      end
      if (seq_done) begin
         rsp_ff <= result;
      end
   end

   assign rsp_ch.valid       = rsp_vld_ff;
   assign rsp_ch.min_valid   = rsp_ff.min_valid;
   assign rsp_ch.min_key     = rsp_ff.min_key;
   assign rsp_ch.min_id      = rsp_ff.min_id;
   assign rsp_ch.entry_count = rsp_ff.entry_count;
   assign rsp_ch.status      = rsp_ff.status;

   assign rsp_min_zero = (rsp_ff.min_key == 32'd0) && (rsp_ff.min_id == 8'd0);

   `IMHQ_NEXT(a_busy_after_accept, clock, reset, start, !req_ch.ready)
   `IMHQ_IMPLIES(a_empty_min_zero, clock, reset, rsp_vld_ff && !rsp_ff.min_valid, rsp_min_zero)
   `IMHQ_IMPLIES(a_full_not_empty, clock, reset, rsp_vld_ff && rsp_ff.status == ST_FULL, rsp_ff.min_valid)

endmodule

// File: rtl/imhq_ram.sv
module imhq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/imhq_key_cmp.sv
module imhq_key_cmp #(
   parameter int KEY_BITS = 32
) (
   input  logic [KEY_BITS-1:0] a_key,
   input  logic [KEY_BITS-1:0] b_key,
   output logic                a_le_b
);

   assign a_le_b = (a_key <= b_key);

endmodule

// File: rtl/imhq_seq.sv
module imhq_seq
   import imhq_pkg::*;
#(
   parameter int HEAP_SLOTS = 256,
   parameter int ENTRY_IDS  = 256,
   parameter int KEY_BITS   = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  req_item_type start_item,
   input  logic         out_free,
   output logic         idle,
   output logic         done,
   output rsp_item_type result
);

   localparam int SW = $clog2(HEAP_SLOTS);
   localparam int LD = (ENTRY_IDS < 256) ? ENTRY_IDS : 256;
   localparam int LA = $clog2(LD);
   localparam int EW = KEY_BITS + 8;

   typedef enum logic [12:0] {
      S_IDLE     = 13'b0000000000001,
      S_LOC      = 13'b0000000000010,
      S_DEL_TOP  = 13'b0000000000100,
      S_DEL_LAST = 13'b0000000001000,
      S_ALT_RD   = 13'b0000000010000,
      S_DN_L     = 13'b0000000100000,
      S_DN_R     = 13'b0000001000000,
      S_DN_C     = 13'b0000010000000,
      S_UP_P     = 13'b0000100000000,
      S_UP_C     = 13'b0001000000000,
      S_PUT      = 13'b0010000000000,
      S_FIN      = 13'b0100000000000,
      S_OUT      = 13'b1000000000000
   } state_type;

   state_type           state_ff, state_in;
   logic [1:0]          op_ff, op_in;
   logic [7:0]          id_ff, id_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   status_type          status_ff, status_in;
   logic [SW-1:0]       held_ff, held_in;
   logic [SW-1:0]       cur_ff, cur_in;
   logic [KEY_BITS-1:0] mov_key_ff, mov_key_in;
   logic [7:0]          mov_id_ff, mov_id_in;
   logic [KEY_BITS-1:0] best_key_ff, best_key_in;
   logic [7:0]          best_id_ff, best_id_in;
   logic                pick_l_ff, pick_l_in;
   logic [LD-1:0]       vld_ff, vld_in;

   logic [SW-1:0]       heap_ra, heap_wa;
   logic                heap_we;
   logic [EW-1:0]       heap_wd, heap_rd;
   logic [KEY_BITS-1:0] rd_key;
   logic [7:0]          rd_id;
   logic                loc_we;
   logic [LA-1:0]       loc_wa;
   logic [SW-1:0]       loc_wd, loc_rd, loc_val;
   logic [KEY_BITS-1:0] cmp_a, cmp_b;
   logic                cmp_le;
   logic                known;
   logic [SW:0]         lft;
   logic                has_left, has_right;

   imhq_ram #(.WIDTH(EW), .DEPTH(HEAP_SLOTS)) u_heap_ram (
      .clock   (clock),
      .wr_en   (heap_we),
      .wr_addr (heap_wa),
      .wr_data (heap_wd),
      .rd_addr (heap_ra),
      .rd_data (heap_rd)
   );

   imhq_ram #(.WIDTH(SW), .DEPTH(LD)) u_loc_ram (
      .clock   (clock),
      .wr_en   (loc_we),
      .wr_addr (loc_wa),
      .wr_data (loc_wd),
      .rd_addr (start_item.entry_id[LA-1:0]),
      .rd_data (loc_rd)
   );

   imhq_key_cmp #(.KEY_BITS(KEY_BITS)) u_cmp (
      .a_key  (cmp_a),
      .b_key  (cmp_b),
      .a_le_b (cmp_le)
   );

   assign rd_key    = heap_rd[EW-1:8];
   assign rd_id     = heap_rd[7:0];
   assign known     = ({1'b0, id_ff} < 9'(LD));
   assign loc_val   = (known && vld_ff[id_ff[LA-1:0]]) ? loc_rd : '0;
   assign lft       = {cur_ff, 1'b0};
   assign has_left  = (lft <= {1'b0, held_ff});
   assign has_right = (lft < {1'b0, held_ff});
   assign idle      = (state_ff == S_IDLE);

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      id_in       = id_ff;
      key_in      = key_ff;
      status_in   = status_ff;
      held_in     = held_ff;
      cur_in      = cur_ff;
      mov_key_in  = mov_key_ff;
      mov_id_in   = mov_id_ff;
      best_key_in = best_key_ff;
      best_id_in  = best_id_ff;
      pick_l_in   = pick_l_ff;
      vld_in      = vld_ff;
      heap_ra     = SW'(1);
      heap_we     = 1'b0;
      heap_wa     = cur_ff;
      heap_wd     = {mov_key_ff, mov_id_ff};
      loc_we      = 1'b0;
      loc_wa      = mov_id_ff[LA-1:0];
      loc_wd      = cur_ff;
      cmp_a       = rd_key;
      cmp_b       = mov_key_ff;
      done        = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in     = start_item.req_type;
               id_in     = start_item.entry_id;
               key_in    = KEY_BITS'(start_item.new_key);
               status_in = ST_OK;
               state_in  = S_LOC;
            end
         end
         S_LOC: begin
            mov_key_in = key_ff;
            mov_id_in  = id_ff;
            cur_in     = loc_val;
            heap_ra    = loc_val;
            unique case (op_ff)
               OP_INSERT: begin
                  if (!known) begin
                     status_in = ST_ABSENT;
                     state_in  = S_FIN;
                  end else if (loc_val != '0) begin
                     state_in = S_ALT_RD;
                  end else if (held_ff == SW'(HEAP_SLOTS - 1)) begin
                     status_in = ST_FULL;
                     state_in  = S_FIN;
                  end else begin
                     held_in  = held_ff + SW'(1);
                     cur_in   = held_ff + SW'(1);
                     state_in = S_UP_P;
                  end
               end
               OP_DELETE: begin
                  heap_ra = SW'(1);
                  if (held_ff == '0) begin
                     status_in = ST_EMPTY;
                     state_in  = S_FIN;
                  end else begin
                     state_in = S_DEL_TOP;
                  end
               end
               OP_ALTER: begin
                  if (loc_val == '0) begin
                     status_in = ST_ABSENT;
                     state_in  = S_FIN;
                  end else begin
                     state_in = S_ALT_RD;
                  end
               end
               default: begin
                  state_in = S_FIN;
               end
            endcase
         end
         S_DEL_TOP: begin
            vld_in[rd_id[LA-1:0]] = 1'b0;
            heap_ra  = held_ff;
            state_in = S_DEL_LAST;
         end
         S_DEL_LAST: begin
            mov_key_in = rd_key;
            mov_id_in  = rd_id;
            held_in    = held_ff - SW'(1);
            cur_in     = SW'(1);
            state_in   = (held_ff == SW'(1)) ? S_FIN : S_DN_L;
         end
         S_ALT_RD: begin
            mov_id_in = rd_id;
            cmp_b     = key_ff;
            state_in  = cmp_le ? S_DN_L : S_UP_P;
         end
         S_DN_L: begin
            heap_ra = lft[SW-1:0];
            if (has_left) begin
               state_in = S_DN_R;
            end else begin
               state_in = S_PUT;
            end
         end
         S_DN_R: begin
            pick_l_in   = cmp_le;
            best_key_in = cmp_le ? rd_key : mov_key_ff;
            best_id_in  = cmp_le ? rd_id : mov_id_ff;
            heap_ra     = has_right ? SW'(lft + 1'b1) : SW'(1);
            state_in    = S_DN_C;
         end
         S_DN_C: begin
            cmp_b = best_key_ff;
            if (has_right && cmp_le) begin
               heap_we  = 1'b1;
               heap_wd  = heap_rd;
               loc_we   = 1'b1;
               loc_wa   = rd_id[LA-1:0];
               cur_in   = SW'(lft + 1'b1);
               state_in = S_DN_L;
            end else if (pick_l_ff) begin
               heap_we  = 1'b1;
               heap_wd  = {best_key_ff, best_id_ff};
               loc_we   = 1'b1;
               loc_wa   = best_id_ff[LA-1:0];
               cur_in   = lft[SW-1:0];
               state_in = S_DN_L;
            end else begin
               state_in = S_PUT;
            end
         end
         S_UP_P: begin
            heap_ra = cur_ff >> 1;
            if (cur_ff > SW'(1)) begin
               state_in = S_UP_C;
            end else begin
               state_in = S_PUT;
            end
         end
         S_UP_C: begin
            cmp_a = mov_key_ff;
            cmp_b = rd_key;
            if (cmp_le) begin
               heap_we  = 1'b1;
               heap_wd  = heap_rd;
               loc_we   = 1'b1;
               loc_wa   = rd_id[LA-1:0];
               cur_in   = cur_ff >> 1;
               state_in = S_UP_P;
            end else begin
               state_in = S_PUT;
            end
         end
         S_PUT: begin
            heap_we  = 1'b1;
            loc_we   = 1'b1;
            state_in = S_FIN;
         end
         S_FIN: begin
            state_in = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               done     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (loc_we) begin
         vld_in[loc_wa] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         held_ff  <= '0;
         vld_ff   <= '0;
      end else begin
         state_ff <= state_in;
         held_ff  <= held_in;
         vld_ff   <= vld_in;
      end
      op_ff       <= op_in;
      id_ff       <= id_in;
      key_ff      <= key_in;
      status_ff   <= status_in;
      cur_ff      <= cur_in;
      mov_key_ff  <= mov_key_in;
      mov_id_ff   <= mov_id_in;
      best_key_ff <= best_key_in;
      best_id_ff  <= best_id_in;
      pick_l_ff   <= pick_l_in;
   end

   // slot one is read in the finish state and held in the output state
   always_comb begin
      result.min_valid   = (held_ff != '0);
      result.min_key     = (held_ff != '0) ? 32'(rd_key) : 32'd0;
      result.min_id      = (held_ff != '0) ? rd_id : 8'd0;
      result.entry_count = 8'(held_ff);
      result.status      = status_ff;
   end

endmodule

// File: tb/sv/indexed_min_heap_queue_tb.sv
module indexed_min_heap_queue_tb;
   import imhq_pkg::*;

   logic clock;
   logic reset;

   imhq_req_if req_ch ();
   imhq_rsp_if rsp_ch ();

   indexed_min_heap_queue dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch.sink),
      .rsp_ch(rsp_ch.source)
   );

   // heap mirror
   logic [31:0] heap_key [256];
   logic [7:0]  heap_id [256];
   logic [7:0]  id_slot [256];
   int unsigned heap_count;

   rsp_item_type pending_rsp [$];
   bit           pending_known [$];
   rsp_item_type typed_rsp [$];

   int error_count;
   int send_idle_pct;
   int recv_stall_pct;
   bit stim_done;

   typedef struct {
      logic [1:0]  op;
      logic [7:0]  id;
      logic [31:0] key;
      bit          has_rsp;
      rsp_item_type rsp;
   } stim_row_type;

   function automatic rsp_item_type mk_rsp(logic v, logic [31:0] k, logic [7:0] i,
                                           logic [7:0] c, status_type s);
      rsp_item_type r;
      r.min_valid = v;
      r.min_key = k;
      r.min_id = i;
      r.entry_count = c;
      r.status = s;
      return r;
   endfunction

   function automatic void swap_slots(int unsigned a, int unsigned b);
      logic [31:0] tk;
      logic [7:0]  ti;
      tk = heap_key[a];
      ti = heap_id[a];
      heap_key[a] = heap_key[b];
      heap_id[a] = heap_id[b];
      heap_key[b] = tk;
      heap_id[b] = ti;
      id_slot[heap_id[a]] = 8'(a);
      id_slot[heap_id[b]] = 8'(b);
   endfunction

   function automatic void sift_down(int unsigned start);
      int unsigned cur;
      int unsigned pick;
      int unsigned left;
      cur = start;
      forever begin
         pick = cur;
         left = 2 * cur;
         if (left <= heap_count && heap_key[left] <= heap_key[pick]) pick = left;
         if (left < heap_count && heap_key[left + 1] <= heap_key[pick]) pick = left + 1;
         if (pick == cur) break;
         swap_slots(cur, pick);
         cur = pick;
      end
   endfunction

   function automatic void sift_up(int unsigned start);
      int unsigned cur;
      cur = start;
      while (cur > 1 && heap_key[cur / 2] >= heap_key[cur]) begin
         swap_slots(cur, cur / 2);
         cur = cur / 2;
      end
   endfunction

   function automatic void rekey(int unsigned slot, logic [31:0] key);
      logic [31:0] old;
      old = heap_key[slot];
      heap_key[slot] = key;
      if (key >= old) sift_down(slot);
      else sift_up(slot);
   endfunction

   function automatic rsp_item_type heap_apply(logic [1:0] op, logic [7:0] id,
                                               logic [31:0] key);
      status_type st;
      int unsigned loc;
      st = ST_OK;
      loc = id_slot[id];
      if (op == OP_INSERT) begin
         if (loc != 0) rekey(loc, key);
         else if (heap_count + 1 >= 256) st = ST_FULL;
         else begin
            heap_count++;
            heap_key[heap_count] = key;
            heap_id[heap_count] = id;
            id_slot[id] = 8'(heap_count);
            sift_up(heap_count);
         end
      end else if (op == OP_DELETE) begin
         if (heap_count == 0) st = ST_EMPTY;
         else begin
            id_slot[heap_id[1]] = 0;
            heap_key[1] = heap_key[heap_count];
            heap_id[1] = heap_id[heap_count];
            heap_count--;
            if (heap_count > 0) begin
               id_slot[heap_id[1]] = 1;
               sift_down(1);
            end
         end
      end else if (op == OP_ALTER) begin
         if (loc == 0) st = ST_ABSENT;
         else rekey(loc, key);
      end
      if (heap_count > 0)
         return mk_rsp(1'b1, heap_key[1], heap_id[1], 8'(heap_count), st);
      return mk_rsp(1'b0, '0, '0, 8'(heap_count), st);
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
      error_count++;
   endtask

   task automatic send_request(logic [1:0] op, logic [7:0] id, logic [31:0] key);
      bit idle_now;
      idle_now = ($urandom_range(99) < send_idle_pct);
      if (idle_now) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.req_type <= op;
      req_ch.entry_id <= id;
      req_ch.new_key <= key;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic run_request(logic [1:0] op, logic [7:0] id, logic [31:0] key,
                              bit has_rsp, rsp_item_type rsp);
      rsp_item_type p;
      p = heap_apply(op, id, key);
      pending_rsp.push_back(p);
      pending_known.push_back(has_rsp);
      typed_rsp.push_back(rsp);
      send_request(op, id, key);
   endtask

   task automatic drain_wait();
      req_ch.valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic random_phase(int n);
      int r;
      logic [1:0] op;
      logic [7:0] id;
      logic [31:0] key;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(99);
         if (heap_count < 20) op = (r < 60) ? OP_INSERT : (r < 80 ? OP_ALTER : OP_DELETE);
         else op = (r < 35) ? OP_INSERT : (r < 70 ? OP_ALTER : OP_DELETE);
         if ($urandom_range(99) < 3) op = 2'd3;
         id = $urandom_range(255);
         if (op == OP_ALTER && heap_count > 0 && $urandom_range(99) < 80)
            id = heap_id[$urandom_range(heap_count, 1)];
         case ($urandom_range(3))
            0: key = $urandom_range(15);
            1: key = $urandom;
            2: key = 32'hFFFF_FFF0 | $urandom_range(15);
            default: key = $urandom_range(1000);
         endcase
         run_request(op, id, key, 1'b0, mk_rsp(0, 0, 0, 0, ST_OK));
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #50_000_000;
      $display("indexed_min_heap_queue_tb: errors");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_rsp.size() == 0) begin
               $display("mismatch: unexpected response at %0t", $time);
               error_count++;
            end else begin
               rsp_item_type w;
               w = pending_rsp.pop_front();
               if (pending_known.pop_front()) begin
                  rsp_item_type t;
                  t = typed_rsp.pop_front();
                  if (t != w) report_mismatch("table row", 0, 0);
               end else void'(typed_rsp.pop_front());
               if (rsp_ch.min_valid !== w.min_valid)
                  report_mismatch("min_valid", 32'(rsp_ch.min_valid), 32'(w.min_valid));
               if (rsp_ch.min_key !== w.min_key)
                  report_mismatch("min_key", rsp_ch.min_key, w.min_key);
               if (rsp_ch.min_id !== w.min_id)
                  report_mismatch("min_id", 32'(rsp_ch.min_id), 32'(w.min_id));
               if (rsp_ch.entry_count !== w.entry_count)
                  report_mismatch("entry_count", 32'(rsp_ch.entry_count),
                                  32'(w.entry_count));
               if (rsp_ch.status !== w.status)
                  report_mismatch("status", 32'(rsp_ch.status), 32'(w.status));
            end
         end
      end
   end

   initial begin
      stim_row_type rows [$];
      int waited;
      error_count = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      heap_count = 0;
      for (int i = 0; i < 256; i++) begin
         id_slot[i] = '0;
         heap_key[i] = '0;
         heap_id[i] = '0;
      end
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.req_type = OP_INSERT;
      req_ch.entry_id = '0;
      req_ch.new_key = '0;
      rsp_ch.ready = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      rows = '{
         '{OP_DELETE, 8'd0, 32'd0, 1, mk_rsp(0, 0, 0, 0, ST_EMPTY)},
         '{OP_ALTER, 8'd255, 32'd5, 1, mk_rsp(0, 0, 0, 0, ST_ABSENT)},
         '{2'd3, 8'd1, 32'd1, 1, mk_rsp(0, 0, 0, 0, ST_OK)},
         '{OP_INSERT, 8'd255, 32'hFFFF_FFFF, 1, mk_rsp(1, 32'hFFFF_FFFF, 255, 1, ST_OK)},
         '{OP_INSERT, 8'd0, 32'd0, 1, mk_rsp(1, 0, 0, 2, ST_OK)},
         '{OP_INSERT, 8'd7, 32'd0, 0, mk_rsp(0, 0, 0, 0, ST_OK)},
         '{OP_INSERT, 8'd8, 32'd100, 0, mk_rsp(0, 0, 0, 0, ST_OK)},
         '{OP_INSERT, 8'd9, 32'd100, 0, mk_rsp(0, 0, 0, 0, ST_OK)},
         '{OP_INSERT, 8'd8, 32'd50, 0, mk_rsp(0, 0, 0, 0, ST_OK)},
         '{OP_ALTER, 8'd0, 32'h8000_0000, 0, mk_rsp(0, 0, 0, 0, ST_OK)},
         '{OP_ALTER, 8'd9, 32'd0, 0, mk_rsp(0, 0, 0, 0, ST_OK)},
         '{OP_ALTER, 8'd42, 32'd1, 1, mk_rsp(1, 0, 9, 5, ST_ABSENT)},
         '{OP_DELETE, 8'd0, 32'd0, 0, mk_rsp(0, 0, 0, 0, ST_OK)},
         '{OP_DELETE, 8'd0, 32'd0, 0, mk_rsp(0, 0, 0, 0, ST_OK)},
         '{OP_ALTER, 8'd255, 32'd3, 0, mk_rsp(0, 0, 0, 0, ST_OK)},
         '{OP_DELETE, 8'd0, 32'd0, 0, mk_rsp(0, 0, 0, 0, ST_OK)},
         '{OP_DELETE, 8'd0, 32'd0, 0, mk_rsp(0, 0, 0, 0, ST_OK)},
         '{OP_DELETE, 8'd0, 32'd0, 0, mk_rsp(0, 0, 0, 0, ST_OK)},
         '{OP_DELETE, 8'd0, 32'd0, 1, mk_rsp(0, 0, 0, 0, ST_EMPTY)}
      };
      foreach (rows[i])
         run_request(rows[i].op, rows[i].id, rows[i].key, rows[i].has_rsp, rows[i].rsp);
      drain_wait();

      // fill to capacity then hit full, then empty out
      for (int i = 0; i < 255; i++)
         run_request(OP_INSERT, i[7:0], $urandom_range(255), 1'b0, mk_rsp(0, 0, 0, 0, ST_OK));
      run_request(OP_INSERT, 8'd255, 32'd1, 1'b0, mk_rsp(0, 0, 0, 0, ST_OK));
      drain_wait();
      for (int i = 0; i < 255; i++)
         run_request(OP_DELETE, 8'd0, 32'd0, 1'b0, mk_rsp(0, 0, 0, 0, ST_OK));

      random_phase(40);
      send_idle_pct = 67;
      random_phase(40);
      send_idle_pct = 0;
      recv_stall_pct = 67;
      random_phase(40);
      drain_wait();
      send_idle_pct = 23;
      recv_stall_pct = 23;
      random_phase(35);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      random_phase(15);

      req_ch.valid <= 1'b0;
      waited = 0;
      while (pending_rsp.size() != 0 && waited < 100000) begin
         @(posedge clock);
         waited++;
      end
      repeat (40) @(posedge clock);
      if (error_count == 0 && pending_rsp.size() == 0) begin
         $display("indexed_min_heap_queue_tb: clean");
      end else begin
         if (pending_rsp.size() != 0)
            $display("mismatch: %0d responses never arrived", pending_rsp.size());
         $display("indexed_min_heap_queue_tb: errors");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+rtl
rtl/imhq_pkg.sv
rtl/imhq_ifs.sv
rtl/imhq_ram.sv
rtl/imhq_key_cmp.sv
rtl/imhq_seq.sv
rtl/indexed_min_heap_queue.sv
tb/sv/indexed_min_heap_queue_tb.sv
